@@ hw/rtl/ic_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ic_pkg
// Shared types, constants and microcode table for the inversion counter.
// ----------------------------------------------------------------------------
package ic_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 19;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Microcode step addresses
   typedef enum logic [2:0] {
      S_LOAD       = 3'd0,
      S_INIT       = 3'd1,
      S_PASS       = 3'd2,
      S_GROUP      = 3'd3,
      S_MERGE      = 3'd4,
      S_NEXT_GROUP = 3'd5,
      S_NEXT_PASS  = 3'd6,
      S_FINISH     = 3'd7
   } uc_step_type;

   // Datapath operations
   typedef enum logic [2:0] {
      OP_LOAD,
      OP_INIT,
      OP_PASS,
      OP_GROUP,
      OP_MERGE,
      OP_NEXT_GROUP,
      OP_NEXT_PASS,
      OP_FINISH
   } uc_op_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NOT_LAST,
      COND_SORTED,
      COND_MERGE_MORE,
      COND_GROUP_MORE
   } uc_cond_type;

   typedef struct packed {
      logic        busy;
      uc_op_type   op;
      uc_cond_type cond;
      uc_step_type target;
   } uc_word_type;

   // Status flags from the datapath to the sequencer
   typedef struct packed {
      logic last_beat;
      logic sorted;
      logic merge_more;
      logic group_more;
   } ic_flags_type;

   function automatic uc_word_type ucode_rom(input uc_step_type step);
      uc_word_type word;
      unique case (step)
         S_LOAD:       word = '{1'b0, OP_LOAD,       COND_NOT_LAST,   S_LOAD};
         S_INIT:       word = '{1'b1, OP_INIT,       COND_NEXT,       S_LOAD};
         S_PASS:       word = '{1'b1, OP_PASS,       COND_SORTED,     S_FINISH};
         S_GROUP:      word = '{1'b1, OP_GROUP,      COND_NEXT,       S_LOAD};
         S_MERGE:      word = '{1'b1, OP_MERGE,      COND_MERGE_MORE, S_MERGE};
         S_NEXT_GROUP: word = '{1'b1, OP_NEXT_GROUP, COND_GROUP_MORE, S_GROUP};
         S_NEXT_PASS:  word = '{1'b1, OP_NEXT_PASS,  COND_ALWAYS,     S_PASS};
         S_FINISH:     word = '{1'b1, OP_FINISH,     COND_ALWAYS,     S_LOAD};
         default:      word = '{1'b0, OP_LOAD,       COND_NOT_LAST,   S_LOAD};
      endcase
      return word;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ic_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ic_mem
// Value memory: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module ic_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_a_addr,
   input  wire logic [ADDR_W-1:0] rd_b_addr,
   output logic      [DATA_W-1:0] rd_a_data,
   output logic      [DATA_W-1:0] rd_b_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule
`default_nettype wire

@@ hw/rtl/ic_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ic_sequencer
// Step counter over the microcode table, with conditional jumps.
// ----------------------------------------------------------------------------
module ic_sequencer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ic_pkg::ic_flags_type flags,
   output ic_pkg::uc_word_type       ctl
);

   ic_pkg::uc_step_type step_ff;
   ic_pkg::uc_step_type step_in;
   logic                jump;

   assign ctl = ic_pkg::ucode_rom(step_ff);

   always_comb begin
      unique case (ctl.cond)
         ic_pkg::COND_NEXT:       jump = 1'b0;
         ic_pkg::COND_ALWAYS:     jump = 1'b1;
         ic_pkg::COND_NOT_LAST:   jump = !flags.last_beat;
         ic_pkg::COND_SORTED:     jump = flags.sorted;
         ic_pkg::COND_MERGE_MORE: jump = flags.merge_more;
         ic_pkg::COND_GROUP_MORE: jump = flags.group_more;
         default:                 jump = 1'b0;
      endcase
      step_in = jump ? ctl.target : ic_pkg::uc_step_type'(step_ff + 3'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ic_pkg::S_LOAD;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/ic_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ic_datapath
// Run bounds, merge pointers, pair total and the two ping-pong memories.
// ----------------------------------------------------------------------------
module ic_datapath #(
   parameter int MAX_ITEMS = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ic_pkg::uc_word_type               ctl,
   input  wire logic                              start,
   input  wire logic signed [ic_pkg::VALUE_W-1:0] req_sample_value,
   input  wire logic                              req_is_last,
   output ic_pkg::ic_flags_type                   flags,
   output logic                                   rsp_strobe,
   output logic             [ic_pkg::COUNT_W-1:0] rsp_inversion_count,
   output logic                                   rsp_overflow_flag
);

   localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int WID_W = CNT_W + 1;
   localparam int SUM_W = CNT_W + 2;
   localparam int TOT_W = (2 * CNT_W > ic_pkg::COUNT_W) ? 2 * CNT_W : ic_pkg::COUNT_W + 1;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [TOT_W-1:0] total_ff;
   logic [TOT_W-1:0] total_in;
   logic             ovf_ff;
   logic             ovf_in;
   logic             src_ff;
   logic             src_in;
   logic [WID_W-1:0] width_ff;
   logic [WID_W-1:0] width_in;
   logic [CNT_W-1:0] lo_ff;
   logic [CNT_W-1:0] lo_in;
   logic [CNT_W-1:0] mid_ff;
   logic [CNT_W-1:0] mid_in;
   logic [CNT_W-1:0] hi_ff;
   logic [CNT_W-1:0] hi_in;
   logic [CNT_W-1:0] i_ff;
   logic [CNT_W-1:0] i_in;
   logic [CNT_W-1:0] j_ff;
   logic [CNT_W-1:0] j_in;
   logic [CNT_W-1:0] k_ff;
   logic [CNT_W-1:0] k_in;

   logic                       rsp_strobe_ff;
   logic [ic_pkg::COUNT_W-1:0] rsp_count_ff;
   logic [ic_pkg::COUNT_W-1:0] rsp_count_in;
   logic                       rsp_ovf_ff;

   logic [SUM_W-1:0] sum_one;
   logic [SUM_W-1:0] sum_two;
   logic [SUM_W-1:0] n_ext;
   logic             accept;
   logic             room;
   logic             take_j;

   logic [ic_pkg::VALUE_W-1:0] rd0_a;
   logic [ic_pkg::VALUE_W-1:0] rd0_b;
   logic [ic_pkg::VALUE_W-1:0] rd1_a;
   logic [ic_pkg::VALUE_W-1:0] rd1_b;
   logic [ic_pkg::VALUE_W-1:0] val_a;
   logic [ic_pkg::VALUE_W-1:0] val_b;
   logic                       wr0_en;
   logic                       wr1_en;
   logic [IDX_W-1:0]           wr_addr;
   logic [ic_pkg::VALUE_W-1:0] wr_data;

   assign accept  = start && (ctl.op == ic_pkg::OP_LOAD);
   assign room    = count_ff < CNT_W'(MAX_ITEMS);
   assign sum_one = SUM_W'(lo_ff) + SUM_W'(width_ff);
   assign sum_two = SUM_W'(lo_ff) + SUM_W'({width_ff, 1'b0});
   assign n_ext   = SUM_W'(count_ff);

   // Read ports follow the source select; data is in step with the pointers
   assign val_a  = src_ff ? rd1_a : rd0_a;
   assign val_b  = src_ff ? rd1_b : rd0_b;
   assign take_j = (j_ff < hi_ff) && ((i_ff >= mid_ff) || ($signed(val_a) > $signed(val_b)));

   assign flags.last_beat  = accept && req_is_last;
   assign flags.sorted     = SUM_W'(width_ff) >= n_ext;
   assign flags.merge_more = (k_ff + CNT_W'(1)) < hi_ff;
   assign flags.group_more = sum_two < n_ext;

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      ovf_in   = ovf_ff;
      src_in   = src_ff;
      width_in = width_ff;
      lo_in    = lo_ff;
      mid_in   = mid_ff;
      hi_in    = hi_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      wr0_en   = 1'b0;
      wr1_en   = 1'b0;
      wr_addr  = k_ff[IDX_W-1:0];
      wr_data  = take_j ? val_b : val_a;
      unique case (ctl.op)
         ic_pkg::OP_LOAD: begin
            wr_addr = count_ff[IDX_W-1:0];
            wr_data = req_sample_value;
            if (accept) begin
               if (room) begin
                  wr0_en   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ic_pkg::OP_INIT: begin
            width_in = WID_W'(1);
            src_in   = 1'b0;
            total_in = '0;
         end
         ic_pkg::OP_PASS: begin
            lo_in = '0;
         end
         ic_pkg::OP_GROUP: begin
            mid_in = (sum_one < n_ext) ? sum_one[CNT_W-1:0] : count_ff;
            hi_in  = (sum_two < n_ext) ? sum_two[CNT_W-1:0] : count_ff;
            i_in   = lo_ff;
            j_in   = mid_in;
            k_in   = lo_ff;
         end
         ic_pkg::OP_MERGE: begin
            wr0_en = src_ff;
            wr1_en = !src_ff;
            k_in   = k_ff + CNT_W'(1);
            if (take_j) begin
               j_in     = j_ff + CNT_W'(1);
               total_in = total_ff + TOT_W'(mid_ff - i_ff);
            end else begin
               i_in = i_ff + CNT_W'(1);
            end
         end
         ic_pkg::OP_NEXT_GROUP: begin
            lo_in = sum_two[CNT_W-1:0];
         end
         ic_pkg::OP_NEXT_PASS: begin
            width_in = width_ff << 1;
            src_in   = !src_ff;
         end
         ic_pkg::OP_FINISH: begin
            count_in = '0;
            total_in = '0;
            ovf_in   = 1'b0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign rsp_count_in = (total_ff > TOT_W'(ic_pkg::COUNT_MAX))
                       ? ic_pkg::COUNT_MAX : total_ff[ic_pkg::COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         total_ff      <= '0;
         ovf_ff        <= 1'b0;
         src_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         total_ff      <= total_in;
         ovf_ff        <= ovf_in;
         src_ff        <= src_in;
         rsp_strobe_ff <= (ctl.op == ic_pkg::OP_FINISH);
      end
      width_ff <= width_in;
      lo_ff    <= lo_in;
      mid_ff   <= mid_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      if (ctl.op == ic_pkg::OP_FINISH) begin
         rsp_count_ff <= rsp_count_in;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   ic_mem #(
      .DEPTH (MAX_ITEMS),
      .ADDR_W(IDX_W),
      .DATA_W(ic_pkg::VALUE_W)
   ) u_mem0 (
      .clock    (clock),
      .wr_en    (wr0_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_a_addr(i_in[IDX_W-1:0]),
      .rd_b_addr(j_in[IDX_W-1:0]),
      .rd_a_data(rd0_a),
      .rd_b_data(rd0_b)
   );

   ic_mem #(
      .DEPTH (MAX_ITEMS),
      .ADDR_W(IDX_W),
      .DATA_W(ic_pkg::VALUE_W)
   ) u_mem1 (
      .clock    (clock),
      .wr_en    (wr1_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_a_addr(i_in[IDX_W-1:0]),
      .rd_b_addr(j_in[IDX_W-1:0]),
      .rd_a_data(rd1_a),
      .rd_b_data(rd1_b)
   );

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_inversion_count = rsp_count_ff;
   assign rsp_overflow_flag   = rsp_ovf_ff;

`ifndef SYNTHESIS
   // Pointers stay inside their runs and account for every written slot
   a_merge_bounds: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == ic_pkg::OP_MERGE) |-> (i_ff <= mid_ff && j_ff <= hi_ff && k_ff < hi_ff))
      else $error("merge pointers out of run bounds");

   a_merge_balance: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == ic_pkg::OP_MERGE) |-> (SUM_W'(k_ff) + SUM_W'(mid_ff) == SUM_W'(i_ff) + SUM_W'(j_ff)))
      else $error("merge output index out of step with read pointers");

   a_strobe_from_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(ctl.op == ic_pkg::OP_FINISH))
      else $error("result strobe without finish step");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("element count beyond capacity");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/inversion_counter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inversion_counter_core
// Counts strictly inverted pairs of a loaded sequence with a merge sort.
// ----------------------------------------------------------------------------
// Loading: one beat per cycle, busy stays low until the beat marked last.
// Sorting n elements over L = ceil(log2 n) passes: each pass sets up and
//   merges each run group in turn, one element per merge cycle (one write
//   port per memory), then swaps the memories and doubles the run width.
// Result strobes the cycle after the finish step, as busy drops; the receiver cannot stall.
// Reset (synchronous) returns the sequencer to loading and clears the element count, pair total and overflow flag.
// ----------------------------------------------------------------------------
module inversion_counter_core #(
   parameter int MAX_ITEMS = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [ic_pkg::VALUE_W-1:0] req_sample_value,
   input  wire logic                              req_is_last,
   output logic                                   rsp_strobe,
   output logic             [ic_pkg::COUNT_W-1:0] rsp_inversion_count,
   output logic                                   rsp_overflow_flag
);

   ic_pkg::uc_word_type  ctl;
   ic_pkg::ic_flags_type flags;

   // The control word of the current step drives the datapath directly
   ic_sequencer u_seq (
      .clock(clock),
      .reset(reset),
      .flags(flags),
      .ctl  (ctl)
   );

   // Busy comes straight from the microcode: only the load step takes beats
   assign busy = ctl.busy;

   ic_datapath #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .start              (start),
      .req_sample_value   (req_sample_value),
      .req_is_last        (req_is_last),
      .flags              (flags),
      .rsp_strobe         (rsp_strobe),
      .rsp_inversion_count(rsp_inversion_count),
      .rsp_overflow_flag  (rsp_overflow_flag)
   );

`ifndef SYNTHESIS
   // One result per sequence: a strobe always ends a busy stretch
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result strobe outside end of sort");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held more than one cycle");

   // A last beat always starts the sort on the next cycle
   a_last_starts_sort: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_is_last) |=> busy)
      else $error("last beat did not start the sort");
`endif

endmodule
`default_nettype wire

@@ tb/inversion_counter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inversion_counter_checker
// Watches the sample and result channels of the inversion counter, keeps its
// own copy of the loaded sequence, counts inverted pairs when a sequence
// closes and compares each strobed result against the oldest expected one.
// ----------------------------------------------------------------------------
module inversion_counter_checker #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic signed [ic_pkg::VALUE_W-1:0]   req_sample_value,
   input  logic                                req_is_last,
   input  logic                                rsp_strobe,
   input  logic        [ic_pkg::COUNT_W-1:0]   rsp_inversion_count,
   input  logic                                rsp_overflow_flag,
   output int                                  results_pending,
   output int                                  failures
);
   import ic_pkg::*;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               overflow;
   } tally_t;

   logic signed [VALUE_W-1:0] sequence_values [MAX_ITEMS];
   int                        sequence_fill = 0;
   bit                        sequence_overflow = 1'b0;
   tally_t                    awaited_tallies [$];
   int                        mismatch_count = 0;

   initial begin
      results_pending = 0;
      failures = 0;
   end

   // Direct pair count over the stored prefix; equal values do not count.
   function automatic longint count_inversions(int n);
      longint total;
      total = 0;
      for (int i = 0; i < n; i++)
         for (int j = i + 1; j < n; j++)
            if (sequence_values[i] > sequence_values[j])
               total++;
      return total;
   endfunction

   always @(posedge clock) begin
      tally_t want;
      longint pairs;
      if (reset) begin
         sequence_fill = 0;
         sequence_overflow = 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (awaited_tallies.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result: expected none, actual count %0d overflow %0b",
                        $time, rsp_inversion_count, rsp_overflow_flag);
            end else begin
               want = awaited_tallies.pop_front();
               if (rsp_inversion_count !== want.count) begin
                  mismatch_count++;
                  $display("%0t: inversion_count: expected %0d, actual %0d",
                           $time, want.count, rsp_inversion_count);
               end
               if (rsp_overflow_flag !== want.overflow) begin
                  mismatch_count++;
                  $display("%0t: overflow_flag: expected %0b, actual %0b",
                           $time, want.overflow, rsp_overflow_flag);
               end
            end
         end
         if (start && !busy) begin
            // drop samples beyond capacity, but remember that they came
            if (sequence_fill < MAX_ITEMS) begin
               sequence_values[sequence_fill] = req_sample_value;
               sequence_fill++;
            end else begin
               sequence_overflow = 1'b1;
            end
            if (req_is_last) begin
               pairs = count_inversions(sequence_fill);
               if (pairs > COUNT_MAX)
                  pairs = COUNT_MAX;
               want.count = pairs[COUNT_W-1:0];
               want.overflow = sequence_overflow;
               awaited_tallies.push_back(want);
               sequence_fill = 0;
               sequence_overflow = 1'b0;
            end
         end
      end
      results_pending <= awaited_tallies.size();
      failures <= mismatch_count;
   end

endmodule

@@ tb/inversion_counter_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inversion_counter_core_test
// Drives sequences of signed samples into the inversion counter: a directed
// set of short sequences around the value extremes, random sequences of mixed
// shape and length with random gaps, then a long strictly falling sequence.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module inversion_counter_core_test;
   import ic_pkg::*;

   localparam int MAX_ITEMS = 1024;
   localparam int RANDOM_BEATS = 460;
   localparam int CLOSING_LEN = 128;

   localparam logic signed [VALUE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;

   // Shapes of a random sequence
   typedef enum int {
      FILL_WIDE,
      FILL_NARROW,
      FILL_EDGE,
      FILL_RISING,
      FILL_FALLING
   } fill_kind_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [VALUE_W-1:0] req_sample_value = '0;
   logic                      req_is_last = 1'b0;
   logic                      rsp_strobe;
   logic        [COUNT_W-1:0] rsp_inversion_count;
   logic                      rsp_overflow_flag;

   int results_pending;
   int failures;

   // Sequence staged for sending; the final entry goes out marked last.
   logic signed [VALUE_W-1:0] pattern [$];
   int                        beats_sent = 0;
   int                        gap_odds = 0;   // 0: no gaps, else 1-in-N per beat

   always #2 clock = ~clock;

   inversion_counter_core #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_sample_value(req_sample_value),
      .req_is_last(req_is_last),
      .rsp_strobe(rsp_strobe),
      .rsp_inversion_count(rsp_inversion_count),
      .rsp_overflow_flag(rsp_overflow_flag)
   );

   inversion_counter_checker #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_check (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_sample_value(req_sample_value),
      .req_is_last(req_is_last),
      .rsp_strobe(rsp_strobe),
      .rsp_inversion_count(rsp_inversion_count),
      .rsp_overflow_flag(rsp_overflow_flag),
      .results_pending(results_pending),
      .failures(failures)
   );

   // Present one beat and hold it until the block takes it. Called at a
   // rising edge; returns at the edge that accepted the beat, with start
   // still high so back-to-back beats need no extra NBA on start.
   task automatic send_sample(input logic signed [VALUE_W-1:0] value, input logic last);
      int gap;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         gap = $urandom_range(1, 9);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_sample_value <= value;
      req_is_last <= last;
      // busy is sampled as it stood before the edge, i.e. the accept condition
      do @(posedge clock); while (busy);
      beats_sent++;
   endtask

   // Send the staged sequence, marking its final beat last.
   task automatic send_pattern();
      for (int i = 0; i < pattern.size(); i++)
         send_sample(pattern[i], i == pattern.size() - 1);
   endtask

   // Drop start and hold until every expected result has strobed out. The
   // checker's pending count is registered, so wait for an edge before each check.
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value(fill_kind_t kind, int idx,
                                                            logic signed [VALUE_W-1:0] base,
                                                            int stride);
      case (kind)
         FILL_WIDE:   return $urandom;
         FILL_NARROW: return int'($urandom_range(0, 7)) - 4;
         FILL_EDGE: begin
            case ($urandom_range(0, 5))
               0:       return SAMPLE_MIN;
               1:       return SAMPLE_MAX;
               2:       return 0;
               3:       return -1;
               4:       return SAMPLE_MIN + 1;
               default: return SAMPLE_MAX - 1;
            endcase
         end
         // trends may wrap through the extremes, which only mixes the order
         FILL_RISING: return base + idx * stride;
         default:     return base - idx * stride;
      endcase
   endfunction

   // Build a random sequence: mostly short, now and then a longer one.
   task automatic stage_random_pattern();
      int                        len;
      fill_kind_t                kind;
      logic signed [VALUE_W-1:0] base;
      int                        stride;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: len = $urandom_range(1, 3);
         4, 5, 6, 7: len = $urandom_range(4, 24);
         8:          len = $urandom_range(25, 64);
         default:    len = $urandom_range(65, 128);
      endcase
      kind = fill_kind_t'($urandom_range(0, 4));
      base = $urandom;
      stride = $urandom_range(0, 3);
      pattern.delete();
      for (int i = 0; i < len; i++) begin
         // salt the trends with a stray value now and then
         if ((kind == FILL_RISING || kind == FILL_FALLING) && $urandom_range(0, 7) == 0)
            pattern.push_back($urandom);
         else
            pattern.push_back(pick_value(kind, i, base, stride));
      end
   endtask

   initial begin
      // Hold reset, then release it at an edge.
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sequences: single elements at both extremes, the extreme
      // pair in both orders, equal values, the sign boundary, and a short
      // strictly falling run. Random gaps, so beats land on varying phases.
      gap_odds = 3;
      pattern = '{SAMPLE_MIN};                          send_pattern();
      pattern = '{SAMPLE_MAX};                          send_pattern();
      pattern = '{SAMPLE_MAX, SAMPLE_MIN};              send_pattern();
      pattern = '{SAMPLE_MIN, SAMPLE_MAX};              send_pattern();
      pattern = '{32'sd7, 32'sd7, 32'sd7};              send_pattern();
      pattern = '{32'sd0, -32'sd1};                     send_pattern();
      pattern = '{-32'sd1, 32'sd0, SAMPLE_MAX, SAMPLE_MIN}; send_pattern();
      pattern = '{32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1, -32'sd2}; send_pattern();

      // Random sequences. Each picks its own gap density, including none,
      // so some stretches run back to back.
      while (beats_sent < RANDOM_BEATS) begin
         case ($urandom_range(0, 3))
            0:       gap_odds = 0;
            1:       gap_odds = 2;
            2:       gap_odds = 4;
            default: gap_odds = 8;
         endcase
         stage_random_pattern();
         send_pattern();
      end

      // Hold off the sender until every result has come back.
      wait_drained();

      // Closing part, no gaps: a long strictly falling sequence crossing zero,
      // so every pair counts.
      gap_odds = 0;
      pattern.delete();
      for (int i = 0; i < CLOSING_LEN; i++)
         pattern.push_back(CLOSING_LEN / 2 - 1 - i);
      send_pattern();

      // Drain, then wait for any stray strobe.
      wait_drained();
      repeat (16) @(posedge clock);
      if (failures == 0)
         $display("inversion_counter_core_test: done, clean");
      else
         $display("inversion_counter_core_test: done, errors");
      $finish;
   end

   // Watchdog: 4 ms, far past the slowest run.
   initial begin
      #4_000_000;
      $display("inversion_counter_core_test: done, errors");
      $finish;
   end

endmodule
